// ===== rtl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types, codes and constants of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

   localparam int unsigned NUM_FRAMES_DEFAULT = 4096;
   localparam int unsigned WORD_BITS          = 32;
   localparam int unsigned WORD_CAP           = 128;
   localparam int unsigned FRAME_W            = 12;
   localparam int unsigned USABLE_W           = 13;

   localparam logic [USABLE_W-1:0] USABLE_RESET = 13'd4096;
   localparam logic [WORD_BITS-1:0] ALL_USED    = 32'hFFFF_FFFF;

   localparam logic [0:0] REG_USABLE_FRAMES = 1'b0;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_SKIP     = 2'd1,
      STATUS_NO_FRAME = 2'd2
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [FRAME_W-1:0] entry;
      logic               kernel;
      logic               writeable;
   } request_type;

   typedef struct packed {
      status_type         status;
      logic [FRAME_W-1:0] frame;
      logic               present;
      logic               writable;
      logic               user;
   } result_type;

endpackage

// ===== rtl/fba_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// fba_bitmap_mem
// Frame bitmap store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fba_bitmap_mem #(
   parameter int unsigned DEPTH = 128,
   parameter int unsigned AW    = 7
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data_ff,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data
);

   logic [31:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/fba_find_zero.sv =====
// ----------------------------------------------------------------------------
// fba_find_zero
// Shared search unit: lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module fba_find_zero (
   input  logic [31:0] word,
   output logic        found,
   output logic [4:0]  bit_idx
);

   assign found = (word != fba_pkg::ALL_USED);

   always_comb begin
      bit_idx = '0;
      for (int i = 31; i >= 0; i--) begin
         if (!word[i]) begin
            bit_idx = 5'(i);
         end
      end
   end

endmodule

// ===== rtl/fba_seq.sv =====
// ----------------------------------------------------------------------------
// fba_seq
// Sequencer: clears the bitmap after reset, scans words for allocation and
// runs read-modify-write for frees.
// ----------------------------------------------------------------------------
module fba_seq #(
   parameter int unsigned NUM_FRAMES = fba_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fba_pkg::USABLE_W-1:0]      usable_frames,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fba_pkg::request_type              req,
   output logic                              res_valid,
   input  logic                              res_ready,
   output fba_pkg::result_type               res
);

   localparam int unsigned WORDS = NUM_FRAMES / fba_pkg::WORD_BITS;
   localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned CAP   = (WORDS < fba_pkg::WORD_CAP) ? WORDS : fba_pkg::WORD_CAP;
   localparam logic [7:0]    CAP_W     = 8'(CAP);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);
   localparam logic [31:0]   WORDS_W   = 32'(WORDS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_RESP
   } state_type;

   state_type            state_ff;
   logic [AW-1:0]        clr_ff;
   logic [7:0]           addr_ff;
   logic [7:0]           limit_ff;
   logic                 pend_ff;
   logic [7:0]           pend_addr_ff;
   fba_pkg::request_type req_ff;
   fba_pkg::result_type  res_ff;

   logic [7:0]    limit_in;
   logic          issue;
   logic          hit;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          found;
   logic [4:0]    bit_idx;
   logic [6:0]    req_word;

   assign req_word = req.entry[11:5];
   assign limit_in = (usable_frames[12:5] < CAP_W) ? usable_frames[12:5] : CAP_W;
   assign issue    = (state_ff == ST_SCAN) && (addr_ff < limit_ff);
   assign hit      = (state_ff == ST_SCAN) && pend_ff && found;

   assign rd_addr = (state_ff == ST_SCAN) ? AW'(addr_ff) : AW'(req_ff.entry[11:5]);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      priority if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (hit) begin
         wr_en   = 1'b1;
         wr_addr = AW'(pend_addr_ff);
         wr_data = rd_data | (32'd1 << bit_idx);
      end else if (state_ff == ST_FREE_WR) begin
         wr_en   = 1'b1;
         wr_addr = AW'(req_ff.entry[11:5]);
         wr_data = rd_data & ~(32'd1 << req_ff.entry[4:0]);
      end
   end

   fba_bitmap_mem #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_mem (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   fba_find_zero u_find (
      .word    (rd_data),
      .found   (found),
      .bit_idx (bit_idx)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESP);
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req;
                  addr_ff  <= '0;
                  pend_ff  <= 1'b0;
                  limit_ff <= limit_in;
                  priority if (req.op == fba_pkg::OP_ALLOC && req.entry != '0) begin
                     res_ff   <= '{status: fba_pkg::STATUS_SKIP, frame: req.entry,
                                   present: 1'b0, writable: 1'b0, user: 1'b0};
                     state_ff <= ST_RESP;
                  end else if (req.op == fba_pkg::OP_ALLOC) begin
                     state_ff <= ST_SCAN;
                  end else if (req.entry == '0) begin
                     res_ff   <= '{status: fba_pkg::STATUS_SKIP, frame: '0,
                                   present: 1'b0, writable: 1'b0, user: 1'b0};
                     state_ff <= ST_RESP;
                  end else if ({25'd0, req_word} >= WORDS_W) begin
                     res_ff   <= '{status: fba_pkg::STATUS_DONE, frame: '0,
                                   present: 1'b0, writable: 1'b0, user: 1'b0};
                     state_ff <= ST_RESP;
                  end else begin
                     state_ff <= ST_FREE_RD;
                  end
               end
            end
            ST_SCAN: begin
               pend_ff      <= issue;
               pend_addr_ff <= addr_ff;
               if (issue) begin
                  addr_ff <= addr_ff + 1'b1;
               end
               priority if (hit) begin
                  res_ff <= '{status: fba_pkg::STATUS_DONE,
                              frame: {pend_addr_ff[6:0], bit_idx},
                              present: 1'b1, writable: req_ff.writeable,
                              user: ~req_ff.kernel};
                  state_ff <= ST_RESP;
               end else if (!issue && !pend_ff) begin
                  res_ff <= '{status: fba_pkg::STATUS_NO_FRAME, frame: '0,
                              present: 1'b0, writable: 1'b0, user: 1'b0};
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_FREE_RD: begin
               state_ff <= ST_FREE_WR;
            end
            ST_FREE_WR: begin
               res_ff <= '{status: fba_pkg::STATUS_DONE, frame: '0,
                           present: 1'b0, writable: 1'b0, user: 1'b0};
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
               clr_ff   <= '0;
            end
         endcase
      end
   end

endmodule

// ===== rtl/frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page frame allocator over a bitmap of physical frames.
//
// Requests arrive on the req_ stream (tuser: allocate or free), results leave
// on the rsp_ stream through an output register, one result per request.
// The csr_ port holds usable_frames, which bounds the search to whole
// 32-frame words.
// After reset the bitmap memory is swept to zero, one word a cycle, through
// all NUM_FRAMES/32 words; req_tready stays low meanwhile.
// An allocation reads one bitmap word a cycle through a single read port
// and tests it in the shared search unit; the search ends at the first word
// with a free frame or after the last word that usable_frames allows, and
// its result passes from the sequencer's result register to the output
// register. A free first reads and then writes its bitmap word; a
// skipped request or a free beyond the bitmap goes to the result register
// directly. req_tready rises as the result enters the output register.
// One request is handled at a time; a stalled receiver holds the result in
// the output register while the next request is taken and worked on.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
   parameter int unsigned NUM_FRAMES = fba_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // entry_frame[11:0], kernel_page[12], writable_page[13]
   input  logic        req_tuser,   // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // new_frame[11:0], present_flag[12], write_flag[13],
                                    // user_flag[14]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [fba_pkg::USABLE_W-1:0] usable_ff;
   logic                         rsp_valid_ff;
   fba_pkg::result_type          rsp_ff;

   fba_pkg::request_type req;
   fba_pkg::result_type  res;
   logic                 res_valid;
   logic                 res_ready;
   logic                 csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2:2] == fba_pkg::REG_USABLE_FRAMES);
   assign csr_prdata = csr_hit ? {19'd0, usable_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= fba_pkg::USABLE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         usable_ff <= csr_pwdata[fba_pkg::USABLE_W-1:0];
      end
   end

   assign req = '{op: fba_pkg::op_type'(req_tuser), entry: req_tdata[11:0],
                  kernel: req_tdata[12], writeable: req_tdata[13]};

   fba_seq #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .usable_frames (usable_ff),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req           (req),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (res_ready) begin
            rsp_valid_ff <= res_valid;
         end
      end
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {1'b0, rsp_ff.user, rsp_ff.writable, rsp_ff.present, rsp_ff.frame};

endmodule
